[src/plar_pkg.sv]
// Shared types and constants of the polyline arc-length resampler.
package plar_pkg;

    // Field widths
    localparam int COORD_BITS = 24;
    localparam int STEP_BITS  = 24;

    // Derived datapath widths
    localparam int QUO_BITS = COORD_BITS + 1;                 // |delta| and interp quotient
    localparam int LEN_BITS = COORD_BITS + 2;                 // segment length
    localparam int SUM_BITS = 2 * LEN_BITS;                   // dx^2 + dy^2
    localparam int END_BITS = ((LEN_BITS > STEP_BITS) ? LEN_BITS : STEP_BITS) + 1;
    localparam int NUM_BITS = COORD_BITS + LEN_BITS + 3;      // 2*|d|*off + len

    localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(256);
    localparam logic [STEP_BITS-1:0] LEFTOVER_MIN = STEP_BITS'(25);

    // Point kinds
    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_INTERP = 2'd1;
    localparam logic [1:0] KIND_FINAL  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         path_end;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [1:0]                   point_kind;
        logic                         run_last;
        logic                         path_done;
        logic                         overflow;
    } t_out;

    // Sequencing of one interpolation lane
    typedef struct packed {
        logic load_mul;
        logic mul_step;
        logic load_div;
        logic div_step;
    } t_lane_ctl;

endpackage

[src/plar_lane.sv]
// One coordinate lane: serial multiply and serial rounding divide for interpolation.
module plar_lane (
    input  logic                                i_clk,
    input  plar_pkg::t_lane_ctl                 i_ctl,
    input  logic [plar_pkg::QUO_BITS-1:0]       i_mag,
    input  logic [plar_pkg::LEN_BITS-1:0]       i_off,
    input  logic [plar_pkg::LEN_BITS-1:0]       i_len,
    output logic [plar_pkg::QUO_BITS-1:0]       o_quo
);
    localparam int NB = plar_pkg::NUM_BITS;
    localparam int LB = plar_pkg::LEN_BITS;
    localparam int QB = plar_pkg::QUO_BITS;

    logic [NB-1:0] r_acc;
    logic [LB-1:0] r_off;
    logic [LB:0]   r_rem;
    logic [QB-1:0] r_quo;

    logic [NB-1:0] w_num;
    logic [LB+1:0] w_trial;
    logic [LB+1:0] w_den;
    logic [LB+1:0] w_diff;
    logic          w_ge;

    // numerator 2*|d|*off + len, divisor 2*len
    assign w_num   = {r_acc[NB-2:0], 1'b0} + NB'(i_len);
    assign w_trial = {r_rem, r_quo[QB-1]};
    assign w_den   = {1'b0, i_len, 1'b0};
    assign w_ge    = (w_trial >= w_den);
    assign w_diff  = w_trial - w_den;

    // multiply one bit of the offset per cycle, then restoring divide
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_mul) begin
            r_acc <= '0;
            r_off <= i_off;
        end else if (i_ctl.mul_step) begin
            r_acc <= {r_acc[NB-2:0], 1'b0} + (r_off[LB-1] ? NB'(i_mag) : '0);
            r_off <= {r_off[LB-2:0], 1'b0};
        end
        if (i_ctl.load_div) begin
            r_rem <= w_num[QB+LB:QB];
            r_quo <= w_num[QB-1:0];
        end else if (i_ctl.div_step) begin
            r_rem <= w_ge ? w_diff[LB:0] : w_trial[LB:0];
            r_quo <= {r_quo[QB-2:0], w_ge};
        end
    end

    assign o_quo = r_quo;

endmodule

[src/polyline_arc_length_resampler_top.sv]
// Polyline arc-length resampler: top level with sequencer, serial sqrt and step divider.
//
// One vertex is worked on at a time. A first vertex of a path is sent out as it is. A later
// vertex goes through setup (the transfer, the serial squares, the bit-pair square root,
// the bit-serial divide of the arc end by the step, plus the end-sum and planning steps),
// then a serial multiply and a restoring divide per interpolated point (x and y in parallel
// lanes), a step for a copied final vertex and one to close the vertex; a stalled output
// adds its wait. The output register lets a finished point wait while work goes on;
// o_in_ready is high only between vertices.
module polyline_arc_length_resampler_top #(
    parameter int MAX_POINTS_PER_VERTEX = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  plar_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output plar_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [plar_pkg::STEP_BITS-1:0]   i_cfg_data
);
    localparam int CB = plar_pkg::COORD_BITS;
    localparam int SB = plar_pkg::STEP_BITS;
    localparam int QB = plar_pkg::QUO_BITS;
    localparam int LB = plar_pkg::LEN_BITS;
    localparam int WB = plar_pkg::SUM_BITS;
    localparam int EB = plar_pkg::END_BITS;
    localparam int KW = $clog2(MAX_POINTS_PER_VERTEX + 1);
    localparam int CW = $clog2(EB + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_SQ     = 4'd2;
    localparam logic [3:0] S_SQRT   = 4'd3;
    localparam logic [3:0] S_ENDSUM = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PLAN   = 4'd6;
    localparam logic [3:0] S_PT_OFF = 4'd7;
    localparam logic [3:0] S_PT_MUL = 4'd8;
    localparam logic [3:0] S_PT_LD  = 4'd9;
    localparam logic [3:0] S_PT_DIV = 4'd10;
    localparam logic [3:0] S_PT_EMT = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_WRAP   = 4'd13;

    logic [3:0]          r_state;
    logic [SB-1:0]       r_step;
    logic signed [CB-1:0] r_prev_x, r_prev_y, r_cur_x, r_cur_y;
    logic                r_pe, r_await;
    logic [SB-1:0]       r_seg;
    logic [QB-1:0]       r_ax, r_ay, r_sx, r_sy;
    logic                r_nx, r_ny;
    logic [WB-1:0]       r_sum;
    logic [LB:0]         r_rsq;
    logic [LB-1:0]       r_len;
    logic [EB-1:0]       r_end;
    logic [SB-1:0]       r_drem;
    logic [SB-1:0]       r_stp;
    logic [KW-1:0]       r_m, r_k;
    logic                r_ovf, r_fin;
    logic [EB-1:0]       r_pos;
    logic [CW-1:0]       r_cnt;
    plar_pkg::t_out      r_out;
    logic                r_out_valid;

    logic                w_accept, w_out_free;
    logic signed [QB-1:0] w_dx, w_dy;
    logic [LB+2:0]       w_sq_t, w_sq_trial, w_sq_diff;
    logic [SB:0]         w_dv_t, w_dv_diff;
    logic                w_dv_ge;
    logic [EB-1:0]       w_cap;
    logic [EB-1:0]       w_seg_e;
    logic [LB-1:0]       w_off;
    logic [QB-1:0]       w_qx, w_qy;
    logic signed [QB:0]  w_px, w_py;
    logic                w_len_zero, w_k_last;
    plar_pkg::t_lane_ctl w_ctl;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // delta to previous vertex
    assign w_dx = QB'(i_in_data.point_x) - QB'(r_prev_x);
    assign w_dy = QB'(i_in_data.point_y) - QB'(r_prev_y);

    // square root: two bits of the sum per cycle
    assign w_sq_t     = {r_rsq, r_sum[WB-1:WB-2]};
    assign w_sq_trial = {1'b0, r_len, 2'b01};
    assign w_sq_diff  = w_sq_t - w_sq_trial;

    // arc end divided by step, one quotient bit per cycle
    assign w_dv_t    = {r_drem, r_end[EB-1]};
    assign w_dv_ge   = (w_dv_t >= {1'b0, r_stp});
    assign w_dv_diff = w_dv_t - {1'b0, r_stp};

    assign w_cap   = EB'(MAX_POINTS_PER_VERTEX) - EB'(r_pe);
    assign w_seg_e = EB'(r_seg);

    // offset of the current point into the segment, clamped to [0, len]
    always_comb begin
        logic [EB-1:0] v_off;
        v_off = (r_pos > w_seg_e) ? (r_pos - w_seg_e) : '0;
        w_off = (v_off > EB'(r_len)) ? r_len : v_off[LB-1:0];
    end

    assign w_ctl.load_mul = (r_state == S_PT_OFF);
    assign w_ctl.mul_step = (r_state == S_PT_MUL);
    assign w_ctl.load_div = (r_state == S_PT_LD);
    assign w_ctl.div_step = (r_state == S_PT_DIV);

    plar_lane u_lane_x (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_mag (r_ax), .i_off (w_off),
        .i_len (r_len), .o_quo (w_qx)
    );
    plar_lane u_lane_y (
        .i_clk (i_clk), .i_ctl (w_ctl), .i_mag (r_ay), .i_off (w_off),
        .i_len (r_len), .o_quo (w_qy)
    );

    // interpolated coordinates
    assign w_len_zero = (r_len == '0);
    assign w_px = (QB+1)'(r_prev_x) + (r_nx ? -(QB+1)'(w_qx) : (QB+1)'(w_qx));
    assign w_py = (QB+1)'(r_prev_y) + (r_ny ? -(QB+1)'(w_qy) : (QB+1)'(w_qy));
    assign w_k_last = (r_k == r_m);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= plar_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            r_step <= i_cfg_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free && (r_state == S_FIRST || r_state == S_PT_EMT
                                    || r_state == S_FIN)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            case (r_state)
                S_FIRST: begin
                    r_out.out_x      <= r_cur_x;
                    r_out.out_y      <= r_cur_y;
                    r_out.point_kind <= plar_pkg::KIND_FIRST;
                    r_out.run_last   <= 1'b1;
                    r_out.path_done  <= r_pe;
                    r_out.overflow   <= 1'b0;
                end
                S_PT_EMT: begin
                    r_out.out_x      <= w_len_zero ? r_prev_x : w_px[CB-1:0];
                    r_out.out_y      <= w_len_zero ? r_prev_y : w_py[CB-1:0];
                    r_out.point_kind <= plar_pkg::KIND_INTERP;
                    r_out.run_last   <= w_k_last && !r_fin;
                    r_out.path_done  <= w_k_last && !r_fin && r_pe;
                    r_out.overflow   <= r_ovf;
                end
                S_FIN: begin
                    r_out.out_x      <= r_cur_x;
                    r_out.out_y      <= r_cur_y;
                    r_out.point_kind <= plar_pkg::KIND_FINAL;
                    r_out.run_last   <= 1'b1;
                    r_out.path_done  <= 1'b1;
                    r_out.overflow   <= r_ovf;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_await  <= 1'b1;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_seg    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cur_x <= i_in_data.point_x;
                        r_cur_y <= i_in_data.point_y;
                        r_pe    <= i_in_data.path_end;
                        r_stp   <= (r_step == '0) ? SB'(1) : r_step;
                        if (r_await) begin
                            r_prev_x <= i_in_data.point_x;
                            r_prev_y <= i_in_data.point_y;
                            r_seg    <= '0;
                            r_await  <= i_in_data.path_end;
                            r_state  <= S_FIRST;
                        end else begin
                            r_nx    <= w_dx[QB-1];
                            r_ny    <= w_dy[QB-1];
                            r_ax    <= w_dx[QB-1] ? -w_dx : w_dx;
                            r_ay    <= w_dy[QB-1] ? -w_dy : w_dy;
                            r_sx    <= w_dx[QB-1] ? -w_dx : w_dx;
                            r_sy    <= w_dy[QB-1] ? -w_dy : w_dy;
                            r_sum   <= '0;
                            r_cnt   <= CW'(QB - 1);
                            r_state <= S_SQ;
                        end
                    end
                end
                S_FIRST: begin
                    if (w_out_free) r_state <= S_IDLE;
                end
                S_SQ: begin
                    r_sum <= {r_sum[WB-2:0], 1'b0}
                             + (r_sx[QB-1] ? WB'(r_ax) : '0)
                             + (r_sy[QB-1] ? WB'(r_ay) : '0);
                    r_sx  <= {r_sx[QB-2:0], 1'b0};
                    r_sy  <= {r_sy[QB-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_rsq   <= '0;
                        r_len   <= '0;
                        r_cnt   <= CW'(LB - 1);
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_SQRT: begin
                    if (w_sq_t >= w_sq_trial) begin
                        r_rsq <= w_sq_diff[LB:0];
                        r_len <= {r_len[LB-2:0], 1'b1};
                    end else begin
                        r_rsq <= w_sq_t[LB:0];
                        r_len <= {r_len[LB-2:0], 1'b0};
                    end
                    r_sum <= {r_sum[WB-3:0], 2'b00};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_ENDSUM;
                end
                S_ENDSUM: begin
                    r_end   <= w_seg_e + EB'(r_len);
                    r_drem  <= '0;
                    r_cnt   <= CW'(EB - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_drem <= w_dv_ge ? w_dv_diff[SB-1:0] : w_dv_t[SB-1:0];
                    r_end  <= {r_end[EB-2:0], w_dv_ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_m   <= (r_end < w_cap) ? r_end[KW-1:0] : w_cap[KW-1:0];
                    r_ovf <= (r_end > w_cap);
                    r_fin <= r_pe && (r_drem > plar_pkg::LEFTOVER_MIN);
                    r_k   <= KW'(1);
                    r_pos <= EB'(r_stp);
                    if (r_end != '0 && w_cap != '0) begin
                        r_state <= S_PT_OFF;
                    end else if (r_pe && (r_drem > plar_pkg::LEFTOVER_MIN)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_WRAP;
                    end
                end
                S_PT_OFF: begin
                    r_cnt   <= CW'(LB - 1);
                    r_state <= S_PT_MUL;
                end
                S_PT_MUL: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_PT_LD;
                end
                S_PT_LD: begin
                    r_cnt   <= CW'(QB - 1);
                    r_state <= S_PT_DIV;
                end
                S_PT_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_PT_EMT;
                end
                S_PT_EMT: begin
                    if (w_out_free) begin
                        if (w_k_last) begin
                            r_state <= r_fin ? S_FIN : S_WRAP;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_pos   <= r_pos + EB'(r_stp);
                            r_state <= S_PT_OFF;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) r_state <= S_WRAP;
                end
                S_WRAP: begin
                    r_prev_x <= r_cur_x;
                    r_prev_y <= r_cur_y;
                    r_await  <= r_pe;
                    r_seg    <= r_pe ? '0 : r_drem;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input taken while a vertex is in work");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.path_done) |-> o_out_data.run_last)
        else $error("path_done without run_last");
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.point_kind == plar_pkg::KIND_FIRST
                         || o_out_data.point_kind == plar_pkg::KIND_INTERP
                         || o_out_data.point_kind == plar_pkg::KIND_FINAL))
        else $error("illegal point kind");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PT_EMT) |-> (r_k <= r_m && r_k != '0))
        else $error("point index out of range");

endmodule

[tb/tb_polyline_arc_length_resampler_top.sv]
// Self-checking testbench for the polyline arc-length resampler top level.
`timescale 1ns / 100ps

module tb_polyline_arc_length_resampler_top;

    localparam int  ITEMS_PER_PHASE = 150;
    localparam longint CYCLE_LIMIT  = 6_000_000;
    localparam int  DRAIN_CYCLES    = 300;
    localparam longint COORD_MAX    = 8388607;
    localparam longint COORD_MIN    = -8388608;
    localparam longint unsigned MAX_PTS = 64;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_in_valid;
    logic                           o_in_ready;
    plar_pkg::t_in                  i_in_data;
    logic                           o_out_valid;
    logic                           i_out_ready;
    plar_pkg::t_out                 o_out_data;
    logic                           i_cfg_we;
    logic [plar_pkg::STEP_BITS-1:0] i_cfg_data;

    polyline_arc_length_resampler_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow state of the resampler
    longint unsigned step_len;
    longint          prev_x, prev_y;
    longint unsigned seg_start, last_emit;
    bit              await_first;

    plar_pkg::t_out pending_points[$];
    int     error_count;
    int     snd_idle, rcv_idle;
    longint cycle_count;

    // Stimulus generator position
    longint gen_x, gen_y;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver stall
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Rounded interpolation offset along one axis
    function automatic longint lerp(longint d, longint unsigned off, longint unsigned len);
        longint unsigned mag, q;
        if (len == 0) return 0;
        mag = (d < 0) ? -d : d;
        q = (2 * mag * off + len) / (2 * len);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned seg_length(longint unsigned s);
        longint unsigned r, c;
        r = 0;
        for (int b = 25; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    // Work out the points one vertex produces and queue them
    task automatic resample_vertex(plar_pkg::t_in v);
        longint x, y, dx, dy;
        longint unsigned len, seg_end, stp, n, cap, m, pos, off;
        bit     ovf;
        plar_pkg::t_out pts[$];
        plar_pkg::t_out p;
        x = v.point_x;
        y = v.point_y;
        if (await_first) begin
            p = '{out_x: v.point_x, out_y: v.point_y, point_kind: plar_pkg::KIND_FIRST,
                  run_last: 1'b1, path_done: v.path_end, overflow: 1'b0};
            pending_points.insert(pending_points.size(), p);
            prev_x = x;
            prev_y = y;
            seg_start = 0;
            last_emit = 0;
            await_first = v.path_end;
            return;
        end
        dx = x - prev_x;
        dy = y - prev_y;
        len = seg_length(dx * dx + dy * dy);
        seg_end = seg_start + len;
        stp = (step_len != 0) ? step_len : 1;
        n = (seg_end >= last_emit) ? (seg_end - last_emit) / stp : 0;
        cap = MAX_PTS - (v.path_end ? 1 : 0);
        m = (n < cap) ? n : cap;
        ovf = (n > cap);
        for (longint unsigned k = 1; k <= m; k++) begin
            pos = last_emit + k * stp;
            off = (pos > seg_start) ? pos - seg_start : 0;
            if (off > len) off = len;
            p = '0;
            p.out_x = plar_pkg::COORD_BITS'(prev_x + lerp(dx, off, len));
            p.out_y = plar_pkg::COORD_BITS'(prev_y + lerp(dy, off, len));
            p.point_kind = plar_pkg::KIND_INTERP;
            p.overflow = ovf;
            pts.insert(pts.size(), p);
        end
        last_emit += n * stp;
        // Copy the final vertex when enough length is left over
        if (v.path_end && seg_end >= last_emit
            && seg_end - last_emit > plar_pkg::LEFTOVER_MIN) begin
            p = '0;
            p.out_x = v.point_x;
            p.out_y = v.point_y;
            p.point_kind = plar_pkg::KIND_FINAL;
            p.overflow = ovf;
            pts.insert(pts.size(), p);
        end
        if (pts.size() > 0) begin
            pts[pts.size()-1].run_last = 1'b1;
            pts[pts.size()-1].path_done = v.path_end;
        end
        foreach (pts[i]) pending_points.insert(pending_points.size(), pts[i]);
        prev_x = x;
        prev_y = y;
        if (v.path_end) begin
            await_first = 1'b1;
            seg_start = 0;
        end else begin
            seg_start = ((seg_end >= last_emit) ? seg_end - last_emit : 0) & 64'hFF_FFFF_FFFF;
        end
        last_emit = 0;
    endtask

    // Output checker
    always @(posedge i_clk) begin
        plar_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected output point x=%0d y=%0d", o_out_data.out_x,
                       o_out_data.out_y);
                error_count++;
            end else begin
                want = pending_points[0];
                pending_points.delete(0);
                if (o_out_data.out_x !== want.out_x) begin
                    $error("out_x: expected %0d got %0d", want.out_x, o_out_data.out_x);
                    error_count++;
                end
                if (o_out_data.out_y !== want.out_y) begin
                    $error("out_y: expected %0d got %0d", want.out_y, o_out_data.out_y);
                    error_count++;
                end
                if (o_out_data.point_kind !== want.point_kind) begin
                    $error("point_kind: expected %0d got %0d", want.point_kind,
                           o_out_data.point_kind);
                    error_count++;
                end
                if (o_out_data.run_last !== want.run_last) begin
                    $error("run_last: expected %0d got %0d", want.run_last,
                           o_out_data.run_last);
                    error_count++;
                end
                if (o_out_data.path_done !== want.path_done) begin
                    $error("path_done: expected %0d got %0d", want.path_done,
                           o_out_data.path_done);
                    error_count++;
                end
                if (o_out_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0d got %0d", want.overflow,
                           o_out_data.overflow);
                    error_count++;
                end
            end
        end
    end

    // One input transfer; expectation queued when the vertex is taken
    task automatic send_vertex(plar_pkg::t_in v);
        bit idled;
        idled = 0;
        while ($urandom_range(99) < snd_idle) begin
            if (!idled) i_in_valid <= 1'b0;
            idled = 1;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do @(posedge i_clk); while (!o_in_ready);
        resample_vertex(v);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step(logic [plar_pkg::STEP_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        step_len = value;
    endtask

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // Random vertices: mostly short hops scaled to the step, some full-range jumps
    task automatic random_phase(int count);
        plar_pkg::t_in v;
        longint span;
        span = (step_len * 3 > 64'd1048576) ? 1048576 : step_len * 3 + 4;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) begin
                gen_x = $signed(plar_pkg::COORD_BITS'($urandom));
                gen_y = $signed(plar_pkg::COORD_BITS'($urandom));
            end else begin
                gen_x = clamp_coord(gen_x + longint'($urandom_range(2 * span)) - span);
                gen_y = clamp_coord(gen_y + longint'($urandom_range(2 * span)) - span);
            end
            v.point_x  = plar_pkg::COORD_BITS'(gen_x);
            v.point_y  = plar_pkg::COORD_BITS'(gen_y);
            v.path_end = ($urandom_range(5) == 0);
            send_vertex(v);
            // Hold off once until the block has drained
            if (i == count / 2 && snd_idle == 71) begin
                i_in_valid <= 1'b0;
                while (pending_points.size() != 0) @(posedge i_clk);
            end
        end
        end_burst();
    endtask

    typedef struct {
        plar_pkg::t_in  vtx;
        bit             typed;
        plar_pkg::t_out want;
    } t_row;

    t_row dir_rows[$];

    initial begin
        t_row r;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        cycle_count = 0;
        error_count = 0;
        snd_idle    = 0;
        rcv_idle    = 0;
        step_len    = 256;
        prev_x = 0; prev_y = 0; seg_start = 0; last_emit = 0; await_first = 1;
        gen_x = 0; gen_y = 0;

        // Directed rows: single-vertex paths at the coordinate extremes
        dir_rows.insert(dir_rows.size(), '{'{24'h7FFFFF, 24'h800000, 1'b1}, 1,
            '{24'h7FFFFF, 24'h800000, plar_pkg::KIND_FIRST, 1'b1, 1'b1, 1'b0}});
        dir_rows.insert(dir_rows.size(), '{'{24'h800000, 24'h7FFFFF, 1'b1}, 1,
            '{24'h800000, 24'h7FFFFF, plar_pkg::KIND_FIRST, 1'b1, 1'b1, 1'b0}});
        // Zero-length segment, plain segment, nothing left at the end
        dir_rows.insert(dir_rows.size(), '{'{24'd0, 24'd0, 1'b0}, 1,
            '{24'd0, 24'd0, plar_pkg::KIND_FIRST, 1'b1, 1'b0, 1'b0}});
        dir_rows.insert(dir_rows.size(), '{'{24'd0, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd1024, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd1024, 24'd5, 1'b1}, 0, '0});
        // Short final segment: the copied vertex alone
        dir_rows.insert(dir_rows.size(), '{'{-24'sd100, -24'sd100, 1'b0}, 1,
            '{-24'sd100, -24'sd100, plar_pkg::KIND_FIRST, 1'b1, 1'b0, 1'b0}});
        dir_rows.insert(dir_rows.size(), '{'{-24'sd100, -24'sd60, 1'b1}, 1,
            '{-24'sd100, -24'sd60, plar_pkg::KIND_FINAL, 1'b1, 1'b1, 1'b0}});
        // Leftover just over and just at the threshold
        dir_rows.insert(dir_rows.size(), '{'{24'd200, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd200, 24'd26, 1'b1}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd300, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd300, 24'd25, 1'b1}, 0, '0});
        // Cap without and with path end, full-range segment
        dir_rows.insert(dir_rows.size(), '{'{24'd0, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'd20000, 24'd0, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{-24'sd20000, 24'd7, 1'b1}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'h800000, 24'h800000, 1'b0}, 0, '0});
        dir_rows.insert(dir_rows.size(), '{'{24'h7FFFFF, 24'h7FFFFF, 1'b1}, 0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.typed) begin
                send_vertex(r.vtx);
                pending_points[pending_points.size()-1] = r.want;
            end else begin
                send_vertex(r.vtx);
            end
        end
        end_burst();

        // Zero step acts as one, with a path left open across the change
        write_step('0);
        send_vertex('{24'd0, 24'd0, 1'b0});
        send_vertex('{24'd5, 24'd3, 1'b0});
        end_burst();
        write_step(24'd1);
        send_vertex('{24'd9, 24'd0, 1'b1});
        end_burst();

        // Random phases with changing step and idling
        snd_idle = 30; rcv_idle = 71;
        random_phase(ITEMS_PER_PHASE);
        write_step(24'hFFFFFF);
        snd_idle = 71; rcv_idle = 30;
        random_phase(ITEMS_PER_PHASE);
        write_step(plar_pkg::STEP_BITS'($urandom_range(4096, 16)));
        snd_idle = 0; rcv_idle = 0;
        random_phase(ITEMS_PER_PHASE);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
